// File: hw/rtl/cave_pkg.sv
// Package for the cave smoothing block: sizes, codes, and the structs
// shared by the interfaces and modules. No dependencies.
`default_nettype none

package cave_pkg;

    // Largest grid side the line buffers hold
    localparam int MAX_GRID = 256;
    localparam int ADDR_W   = $clog2(MAX_GRID);
    localparam int SIZE_W   = 9;
    localparam int IN_ROW_W = ADDR_W + 1;   // input row runs two past the grid
    localparam int COUNT_W  = 4;

    typedef logic [ADDR_W-1:0]   t_coord;
    typedef logic [SIZE_W-1:0]   t_size;
    typedef logic [IN_ROW_W-1:0] t_in_row;
    typedef logic [COUNT_W-1:0]  t_count;

    // Grid side limits and reset value
    localparam t_size  GRID_MIN       = t_size'(3);
    localparam t_size  GRID_MAX       = t_size'(MAX_GRID);
    localparam t_coord RESET_LAST_IDX = t_coord'(63);

    // Neighbor count at which the cell keeps its value
    localparam t_count WALL_PIVOT = t_count'(4);

    // 3x3 neighborhood taps around the cell being decided
    typedef struct packed {
        logic nw;
        logic n;
        logic ne;
        logic w;
        logic ctr;
        logic e;
        logic sw;
        logic s;
        logic se;
    } t_window;

    // Grid border flags for the cell being decided
    typedef struct packed {
        logic top;
        logic bottom;
        logic left;
        logic right;
    } t_edge;

    // One smoothed cell
    typedef struct packed {
        logic   wall;
        t_coord row;
        t_coord column;
        logic   last;
    } t_result;

endpackage

`default_nettype wire

// File: hw/rtl/cave_ifs.sv
// Channel interfaces of the cave smoothing block: cell input, result
// output and grid-size write channel. Depends on cave_pkg.
`default_nettype none

interface cave_in_if;
    logic valid;
    logic ready;
    logic cell_wall;
    logic is_padding;
    modport source (output valid, output cell_wall, output is_padding, input ready);
    modport sink   (input valid, input cell_wall, input is_padding, output ready);
endinterface

interface cave_out_if;
    logic             valid;
    logic             ready;
    logic             wall;
    cave_pkg::t_coord row;
    cave_pkg::t_coord column;
    logic             last;
    modport source (output valid, output wall, output row, output column, output last,
                     input ready);
    modport sink   (input valid, input wall, input row, input column, input last,
                     output ready);
endinterface

interface cave_cfg_if;
    logic            valid;
    logic            ready;
    cave_pkg::t_size data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/cave_cellular_automaton_smoothing_unit.sv
// Cave smoothing unit: one in-place 4-5 cellular automaton pass over a
// square wall grid streamed in scan order.
// Channels: i_in takes one cell per transaction (cell_wall, is_padding);
// o_out gives one smoothed cell per transaction (wall, row, column, last);
// i_cfg writes grid_size, clamped to 3..256, and restarts the pass.
// Throughput: one cell per clock unless the result queue is full, set by
// the combinational decision loop (a cell's result feeds the next cell's
// left neighbor) and by two line buffers, each one write, one read per cycle.
// Results: the result for a cell is pushed on the transaction that brings
// the cell diagonally below-right of it, grid_size+1 items later, into the
// result queue, whose head drives o_out. After the last grid cell, the feeder
// sends grid_size+1 padding items; the result with last set ends the pass.
// Reset: grid_size returns to 64 and a new pass starts; the line buffers
// need no clearing, stale entries reach only row 0's masked north taps.
// Receiver stall: a two-entry result queue keeps accepting cells while one
// result waits; i_in.ready drops only when the queue is full.
// Depends on cave_pkg, cave_ifs, cave_lbuf, cave_rule and cave_ofifo.
`default_nettype none

module cave_cellular_automaton_smoothing_unit (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    cave_in_if.sink    i_in,
    cave_out_if.source o_out,
    cave_cfg_if.sink   i_cfg
);

    cave_pkg::t_coord  r_last_idx, n_last_idx;
    cave_pkg::t_in_row r_in_row, n_in_row;
    cave_pkg::t_coord  r_in_col, n_in_col;
    cave_pkg::t_coord  r_out_row, n_out_row;
    cave_pkg::t_coord  r_out_col, n_out_col;

    // Window taps
    logic r_x1, r_x2;        // raw cells one and two behind the arrival
    logic r_a_prev;          // raw value of the cell being decided
    logic r_up0, r_up1;      // smoothed row above, left and center
    logic r_prev;            // last smoothed result

    logic              w_acc, w_cfg_acc, w_emit, w_last, w_v, w_res, w_full;
    logic              w_a_rdata, w_b_rdata;
    cave_pkg::t_coord  w_b_raddr;
    cave_pkg::t_size   w_side;
    cave_pkg::t_window w_taps;
    cave_pkg::t_edge   w_edge;
    cave_pkg::t_result w_push_data;

    assign i_cfg.ready = 1'b1;
    assign w_cfg_acc   = i_cfg.valid & i_cfg.ready;
    assign i_in.ready  = ~w_full;
    assign w_acc       = i_in.valid & i_in.ready;
    assign w_v         = i_in.is_padding ? 1'b0 : i_in.cell_wall;

    // A result is due once the arrival has reached row 1, column 1
    assign w_emit = (r_in_row != '0)
                  && !((r_in_row == cave_pkg::t_in_row'(1)) && (r_in_col == '0));
    assign w_last = (r_out_row == r_last_idx) && (r_out_col == r_last_idx);

    // Grid size clamp
    always_comb begin
        if (i_cfg.data < cave_pkg::GRID_MIN) begin
            w_side = cave_pkg::GRID_MIN;
        end else if (i_cfg.data > cave_pkg::GRID_MAX) begin
            w_side = cave_pkg::GRID_MAX;
        end else begin
            w_side = i_cfg.data;
        end
    end

    // Scan position counters
    always_comb begin
        n_last_idx = r_last_idx;
        n_in_row   = r_in_row;
        n_in_col   = r_in_col;
        n_out_row  = r_out_row;
        n_out_col  = r_out_col;
        if (w_cfg_acc) begin
            n_last_idx = cave_pkg::t_coord'(w_side - cave_pkg::t_size'(1));
            n_in_row   = '0;
            n_in_col   = '0;
            n_out_row  = '0;
            n_out_col  = '0;
        end else if (w_acc) begin
            if (w_emit && w_last) begin
                n_in_row  = '0;
                n_in_col  = '0;
                n_out_row = '0;
                n_out_col = '0;
            end else begin
                if (r_in_col == r_last_idx) begin
                    n_in_col = '0;
                    n_in_row = r_in_row + cave_pkg::t_in_row'(1);
                end else begin
                    n_in_col = r_in_col + cave_pkg::t_coord'(1);
                end
                if (w_emit) begin
                    if (r_out_col == r_last_idx) begin
                        n_out_col = '0;
                        n_out_row = r_out_row + cave_pkg::t_coord'(1);
                    end else begin
                        n_out_col = r_out_col + cave_pkg::t_coord'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_idx <= cave_pkg::RESET_LAST_IDX;
            r_in_row   <= '0;
            r_in_col   <= '0;
            r_out_row  <= '0;
            r_out_col  <= '0;
        end else begin
            r_last_idx <= n_last_idx;
            r_in_row   <= n_in_row;
            r_in_col   <= n_in_col;
            r_out_row  <= n_out_row;
            r_out_col  <= n_out_col;
        end
    end

    // Raw line buffer: read ahead at the next arrival's column, which holds
    // the raw cell right of the one being decided
    cave_lbuf #(
        .DEPTH (cave_pkg::MAX_GRID),
        .WIDTH (1)
    ) u_raw_lbuf (
        .i_clk   (i_clk),
        .i_we    (w_acc),
        .i_waddr (r_in_col),
        .i_wdata (w_v),
        .i_raddr (n_in_col),
        .o_rdata (w_a_rdata)
    );

    // Smoothed line buffer: read ahead one column past the next result; when
    // the next result ends its row, fetch column 0 instead, the north tap of
    // the first cell in the following row
    assign w_b_raddr = (n_out_col == r_last_idx) ? '0
                     : n_out_col + cave_pkg::t_coord'(1);

    cave_lbuf #(
        .DEPTH (cave_pkg::MAX_GRID),
        .WIDTH (1)
    ) u_smooth_lbuf (
        .i_clk   (i_clk),
        .i_we    (w_acc & w_emit),
        .i_waddr (r_out_col),
        .i_wdata (w_res),
        .i_raddr (w_b_raddr),
        .o_rdata (w_b_rdata)
    );

    // Window shift registers
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_x1     <= w_v;
            r_x2     <= r_x1;
            r_a_prev <= w_a_rdata;
            if (w_emit) begin
                r_up0  <= r_up1;
                r_up1  <= w_b_rdata;
                r_prev <= w_res;
            end
        end
    end

    // Neighborhood of the cell being decided
    always_comb begin
        w_taps.nw  = r_up0;
        w_taps.n   = r_up1;
        w_taps.ne  = w_b_rdata;
        w_taps.w   = r_prev;
        w_taps.ctr = r_a_prev;
        w_taps.e   = w_a_rdata;
        w_taps.sw  = r_x2;
        w_taps.s   = r_x1;
        w_taps.se  = w_v;
        w_edge.top    = (r_out_row == '0);
        w_edge.bottom = (r_out_row == r_last_idx);
        w_edge.left   = (r_out_col == '0);
        w_edge.right  = (r_out_col == r_last_idx);
    end

    cave_rule u_rule (
        .i_taps (w_taps),
        .i_edge (w_edge),
        .o_wall (w_res)
    );

    // Result queue
    always_comb begin
        w_push_data.wall   = w_res;
        w_push_data.row    = r_out_row;
        w_push_data.column = r_out_col;
        w_push_data.last   = w_last;
    end

    cave_ofifo u_ofifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_acc & w_emit),
        .i_data  (w_push_data),
        .o_full  (w_full),
        .o_out   (o_out)
    );

    // The arrival sits one row and one column past the cell being decided, in scan order
    a_emit_offset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && w_emit) |->
            ((r_in_col == r_out_col + cave_pkg::t_coord'(1))
              && (r_in_row == {1'b0, r_out_row} + cave_pkg::t_in_row'(1)))
            || ((r_out_col == r_last_idx) && (r_in_col == '0)
              && (r_in_row == {1'b0, r_out_row} + cave_pkg::t_in_row'(2))))
        else $error("arrival and decided cell out of step");

    // The final cell of the grid restarts the pass
    a_last_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && w_emit && w_last) |=>
            (r_in_row == '0) && (r_in_col == '0) && (r_out_row == '0) && (r_out_col == '0))
        else $error("positions not cleared after last cell");

    // Columns and the result row stay inside the grid
    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_col <= r_last_idx) && (r_out_col <= r_last_idx)
            && (r_out_row <= r_last_idx))
        else $error("scan position beyond grid side");

endmodule

`default_nettype wire

// File: hw/rtl/cave_lbuf.sv
// Generic line buffer, WIDTH bits wide: one write port, one read port with
// registered read data (read-first). No dependencies.
`default_nettype none

module cave_lbuf #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 1
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Read every cycle, write when enabled
    always_ff @(posedge i_clk) begin
        o_rdata <= mem[i_raddr];
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/cave_rule.sv
// Neighbor count and 4-5 decision for one cell, with out-of-grid
// neighbors forced to wall. Depends on cave_pkg.
`default_nettype none

module cave_rule (
    input  wire cave_pkg::t_window i_taps,
    input  wire cave_pkg::t_edge   i_edge,
    output logic                   o_wall
);

    logic nw, n, ne, w, e, sw, s, se;
    cave_pkg::t_count w_count;

    // Border masking: outside the grid counts as wall
    always_comb begin
        nw = i_taps.nw | i_edge.top | i_edge.left;
        n  = i_taps.n  | i_edge.top;
        ne = i_taps.ne | i_edge.top | i_edge.right;
        w  = i_taps.w  | i_edge.left;
        e  = i_taps.e  | i_edge.right;
        sw = i_taps.sw | i_edge.bottom | i_edge.left;
        s  = i_taps.s  | i_edge.bottom;
        se = i_taps.se | i_edge.bottom | i_edge.right;
    end

    assign w_count = cave_pkg::t_count'(nw) + cave_pkg::t_count'(n)
                   + cave_pkg::t_count'(ne) + cave_pkg::t_count'(w)
                   + cave_pkg::t_count'(e)  + cave_pkg::t_count'(sw)
                   + cave_pkg::t_count'(s)  + cave_pkg::t_count'(se);

    // Above pivot: wall, below: open, at pivot: keep center
    always_comb begin
        if (w_count > cave_pkg::WALL_PIVOT) begin
            o_wall = 1'b1;
        end else if (w_count < cave_pkg::WALL_PIVOT) begin
            o_wall = 1'b0;
        end else begin
            o_wall = i_taps.ctr;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/cave_ofifo.sv
// Two-entry result queue between the smoothing pipeline and the output
// channel. Depends on cave_pkg and cave_out_if.
`default_nettype none

module cave_ofifo (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire cave_pkg::t_result i_data,
    output logic                   o_full,
    cave_out_if.source             o_out
);

    cave_pkg::t_result r_ent [2];
    logic              r_wptr, n_wptr;
    logic              r_rptr, n_rptr;
    logic [1:0]        r_count, n_count;
    logic              w_pop;

    assign w_pop  = o_out.valid & o_out.ready;
    assign o_full = (r_count == 2'd2);

    // Pointer and occupancy update
    always_comb begin
        n_wptr  = r_wptr ^ i_push;
        n_rptr  = r_rptr ^ w_pop;
        n_count = r_count + 2'(i_push) - 2'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    // Payload storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_ent[r_wptr] <= i_data;
        end
    end

    // Head entry drives the channel
    assign o_out.valid  = (r_count != 2'd0);
    assign o_out.wall   = r_ent[r_rptr].wall;
    assign o_out.row    = r_ent[r_rptr].row;
    assign o_out.column = r_ent[r_rptr].column;
    assign o_out.last   = r_ent[r_rptr].last;

endmodule

`default_nettype wire

// File: verif/cave_cellular_automaton_smoothing_unit_tb.sv
// Self-checking testbench for the cave smoothing unit: directed and random
// grid passes checked cell by cell against an in-bench prediction.
// Depends on cave_pkg, cave_ifs and the cave_cellular_automaton_smoothing_unit RTL.
`default_nettype none

module cave_cellular_automaton_smoothing_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SETTLE_CYCLES = 8;
    localparam int RANDOM_ITEMS  = 450;
    localparam int LONG_HOLD     = 400;
    localparam int STORE_DEPTH   = 2 * cave_pkg::MAX_GRID + 3;
    localparam cave_pkg::t_size GRID_RESET =
        cave_pkg::t_size'(cave_pkg::RESET_LAST_IDX) + 1'b1;

    logic i_clk = 1'b0;
    logic i_rst_n;

    cave_in_if  in_ch ();
    cave_out_if out_ch ();
    cave_cfg_if cfg_ch ();

    cave_cellular_automaton_smoothing_unit i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    // Predicted grid state: ring of recent cells, scan position, grid register
    logic              cave_store [0:STORE_DEPTH-1];
    int unsigned       in_count;
    cave_pkg::t_size   grid_reg;
    cave_pkg::t_result pending_cells [$];

    int errors       = 0;
    int items_sent   = 0;
    int hold_request = 0;
    bit idle_gaps    = 1'b1;
    bit sink_stalls  = 1'b1;

    // 4 ns clock
    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    // Side length the block works with for a given register value
    function automatic int side_of(input cave_pkg::t_size value);
        if (value < cave_pkg::GRID_MIN) begin
            return int'(cave_pkg::GRID_MIN);
        end
        if (value > cave_pkg::GRID_MAX) begin
            return int'(cave_pkg::GRID_MAX);
        end
        return int'(value);
    endfunction

    // Take in one cell; queue the smoothed cell it completes, if any
    function automatic void smooth_next_cell(input logic cell_wall, input logic is_padding);
        int                side;
        int                ring;
        int                pos;
        int                r;
        int                c;
        int                nr;
        int                nc;
        int                dr;
        int                dc;
        int                count;
        logic              centre;
        logic              smoothed;
        cave_pkg::t_result done_cell;
        side = side_of(grid_reg);
        ring = 2 * side + 3;
        cave_store[in_count % ring] = is_padding ? 1'b0 : cell_wall;
        in_count++;
        if (in_count < side + 2) begin
            return;
        end
        pos   = int'(in_count) - side - 2;
        r     = pos / side;
        c     = pos % side;
        count = 0;
        for (dr = -1; dr <= 1; dr++) begin
            for (dc = -1; dc <= 1; dc++) begin
                if (dr != 0 || dc != 0) begin
                    nr = r + dr;
                    nc = c + dc;
                    // off-grid neighbors count as walls
                    if (nr < 0 || nc < 0 || nr >= side || nc >= side) begin
                        count++;
                    end else begin
                        count += cave_store[(nr * side + nc) % ring];
                    end
                end
            end
        end
        centre = cave_store[pos % ring];
        if (count > cave_pkg::WALL_PIVOT) begin
            smoothed = 1'b1;
        end else if (count < cave_pkg::WALL_PIVOT) begin
            smoothed = 1'b0;
        end else begin
            smoothed = centre;
        end
        // in-place: later cells see the smoothed value
        cave_store[pos % ring] = smoothed;
        done_cell.wall   = smoothed;
        done_cell.row    = cave_pkg::t_coord'(r);
        done_cell.column = cave_pkg::t_coord'(c);
        done_cell.last   = (pos + 1 >= side * side);
        pending_cells    = {pending_cells, done_cell};
        if (done_cell.last) begin
            in_count = 0;
        end
    endfunction

    task automatic check_field(input string what, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, want, got);
            errors++;
        end
    endtask

    // Result checker: every accepted transaction against the oldest prediction
    always @(posedge i_clk) begin : check_cells
        cave_pkg::t_result want_cell;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_cells.size() == 0) begin
                $display("%0t: unexpected cell: expected none, actual row %0d column %0d",
                         $time, out_ch.row, out_ch.column);
                errors++;
            end else begin
                want_cell = pending_cells.pop_front();
                check_field("wall", want_cell.wall, out_ch.wall);
                check_field("row", want_cell.row, out_ch.row);
                check_field("column", want_cell.column, out_ch.column);
                check_field("last", want_cell.last, out_ch.last);
            end
        end
    end

    // Result receiver: random stalls plus the long hold-off on request
    initial begin : result_sink
        out_ch.ready = 1'b1;
        forever begin
            @(negedge i_clk);
            if (hold_request > 0) begin
                out_ch.ready <= 1'b0;
                repeat (hold_request) @(negedge i_clk);
                hold_request = 0;
                out_ch.ready <= 1'b1;
            end else if (sink_stalls && $urandom_range(0, 7) == 0) begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(negedge i_clk);
                out_ch.ready <= 1'b1;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    // One cell transaction; called and returns at a falling edge
    task automatic send_cell(input logic wall, input logic pad);
        if (idle_gaps && $urandom_range(0, 5) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge i_clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.cell_wall  <= wall;
        in_ch.is_padding <= pad;
        do begin
            @(posedge i_clk);
        end while (!in_ch.ready);
        smooth_next_cell(wall, pad);
        items_sent++;
        @(negedge i_clk);
    endtask

    // Items first..stop_at-1 of a pass; stop_at of 0 means the whole pass with flush
    task automatic send_grid(input int side, input int wall_pct, input bit noisy,
                             input int first, input int stop_at);
        int   full;
        int   i;
        logic wall;
        logic pad;
        full = side * side + side + 1;
        if (stop_at <= 0 || stop_at > full) begin
            stop_at = full;
        end
        for (i = first; i < stop_at; i++) begin
            wall = ($urandom_range(0, 99) < wall_pct);
            if (i < side * side) begin
                pad = noisy && ($urandom_range(0, 19) == 0);
            end else begin
                // flush items, now and then sent as plain cells
                pad = !(noisy && ($urandom_range(0, 3) == 0));
            end
            send_cell(wall, pad);
        end
    endtask

    task automatic wait_results_drained();
        in_ch.valid <= 1'b0;
        while (pending_cells.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    // Drain, then give cells that owe no result time to clear the pipe
    task automatic settle_block();
        wait_results_drained();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_grid_size(input cave_pkg::t_size value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= value;
        do begin
            @(posedge i_clk);
        end while (!cfg_ch.ready);
        grid_reg = value;
        in_count = 0;
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // Reset size is 64: a few results of row 0, then a restart by register write
    task automatic test_reset_size();
        send_grid(side_of(grid_reg), 50, 1'b0, 0, 70);
        settle_block();
    endtask

    // Smallest grid: all walls with padding in the middle and plain cells as
    // flush, then all open so edge cells land on exactly four walls
    task automatic test_edge_patterns();
        int i;
        write_grid_size(cave_pkg::GRID_MIN);
        for (i = 0; i < 13; i++) begin
            send_cell(1'b1, i == 4);
        end
        for (i = 0; i < 13; i++) begin
            send_cell(i >= 9, i >= 9);
        end
        settle_block();
    endtask

    // Register values below the floor act as the smallest grid
    task automatic test_size_clamp();
        write_grid_size(cave_pkg::t_size'(0));
        send_grid(side_of(grid_reg), 60, 1'b0, 0, 0);
        settle_block();
        write_grid_size(cave_pkg::t_size'(2));
        send_grid(side_of(grid_reg), 40, 1'b1, 0, 0);
        settle_block();
    endtask

    // Receiver holds off while cells keep coming, so the input stalls
    task automatic test_back_pressure();
        write_grid_size(cave_pkg::t_size'(16));
        hold_request = LONG_HOLD;
        send_grid(side_of(grid_reg), 45, 1'b0, 0, 0);
        settle_block();
    endtask

    // Sender stops mid-pass until all owed results are out, then resumes
    task automatic test_mid_pass_pause();
        write_grid_size(cave_pkg::t_size'(10));
        send_grid(side_of(grid_reg), 50, 1'b0, 0, 60);
        wait_results_drained();
        send_grid(side_of(grid_reg), 50, 1'b0, 60, 0);
        settle_block();
    endtask

    // Mostly complete passes of small random sizes; some noisy, some cut short
    task automatic test_random_passes();
        int start_count;
        int size_pick;
        int side;
        int stop_at;
        int remaining;
        int full;
        bit must_write;
        start_count = items_sent;
        must_write  = 1'b1;
        while (items_sent - start_count < RANDOM_ITEMS) begin
            idle_gaps   = ($urandom_range(0, 3) != 0);
            sink_stalls = ($urandom_range(0, 3) != 0);
            if (must_write || $urandom_range(0, 1) == 0) begin
                settle_block();
                case ($urandom_range(0, 9))
                    0: size_pick = $urandom_range(0, 2);
                    1: size_pick = $urandom_range(13, 32);
                    default: size_pick = $urandom_range(3, 12);
                endcase
                write_grid_size(cave_pkg::t_size'(size_pick));
            end
            side = side_of(grid_reg);
            // a cut-short pass is followed by a register write that restarts it
            must_write = ($urandom_range(0, 9) == 0);
            stop_at    = must_write ? $urandom_range(1, side * side) : 0;
            // the pass that would overrun the item budget is cut short
            remaining  = RANDOM_ITEMS - (items_sent - start_count);
            full       = side * side + side + 1;
            if ((stop_at == 0 ? full : stop_at) > remaining) begin
                stop_at    = remaining;
                must_write = 1'b1;
            end
            send_grid(side, $urandom_range(0, 100), $urandom_range(0, 5) == 0, 0, stop_at);
        end
        idle_gaps   = 1'b1;
        sink_stalls = 1'b1;
        settle_block();
    endtask

    // All-ones register clamps to the largest grid, reaching column 255;
    // then one full small pass with no idling on either side
    task automatic test_largest_grid();
        write_grid_size(cave_pkg::t_size'(511));
        send_grid(side_of(grid_reg), 50, 1'b0, 0, 600);
        settle_block();
        idle_gaps   = 1'b0;
        sink_stalls = 1'b0;
        write_grid_size(cave_pkg::t_size'(8));
        send_grid(side_of(grid_reg), 48, 1'b0, 0, 0);
        settle_block();
    endtask

    // Stimulus sequence
    initial begin
        i_rst_n          = 1'b0;
        in_ch.valid      = 1'b0;
        in_ch.cell_wall  = 1'b0;
        in_ch.is_padding = 1'b0;
        cfg_ch.valid     = 1'b0;
        cfg_ch.data      = '0;
        grid_reg         = GRID_RESET;
        in_count         = 0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_reset_size();
        test_edge_patterns();
        test_size_clamp();
        test_back_pressure();
        test_mid_pass_pause();
        test_random_passes();
        test_largest_grid();

        if (errors == 0) begin
            $display("cave_cellular_automaton_smoothing_unit_tb: clean");
        end else begin
            $display("cave_cellular_automaton_smoothing_unit_tb: errors");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #4_000_000;
        $display("cave_cellular_automaton_smoothing_unit_tb: errors");
        $finish;
    end

endmodule

`default_nettype wire
